FILE: hw/rtl/glrd_pkg.sv
`default_nettype none

package glrd_pkg;

  localparam int BYTE_BITS = 8;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CODE_BITS    = 2'd0,
    REG_START_LEVEL  = 2'd1,
    REG_GLYPH_WIDTH  = 2'd2,
    REG_GLYPH_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0] code_bits;
    logic       start_level;
    logic [7:0] glyph_width;
    logic [7:0] glyph_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       glyph_start;
  } in_beat_t;

  typedef struct packed {
    logic       pixel_on;
    logic [7:0] column;
    logic [7:0] row;
    logic       glyph_done;
    logic       last_of_byte;
  } out_beat_t;

  // flags that travel with each code from front to back
  typedef struct packed {
    logic first;  // first code of its byte
    logic clr;    // byte came with glyph_start
    logic last;   // last code of its byte
  } code_tag_t;

  // code width as used: zero reads as one, large values clamp to the maximum
  function automatic logic [2:0] eff_code_bits(input logic [2:0] cb,
                                               input logic [2:0] max_bits);
    logic [2:0] r;
    if (cb == 3'd0) begin
      r = 3'd1;
    end else if (cb > max_bits) begin
      r = max_bits;
    end else begin
      r = cb;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/glrd_queue.sv
`default_nettype none

module glrd_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  pop_valid,
  output logic [WIDTH-1:0]      pop_data
);

  // two-entry queue between front and back
  logic [WIDTH-1:0] mem_r [2];
  logic [1:0]       count_r, count_nxt;
  logic             wr_ptr_r, rd_ptr_r;
  logic             do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/glrd_front.sv
`default_nettype none

module glrd_front import glrd_pkg::*; #(
  parameter int MAX_CODE_BITS = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     in_valid,
  input  wire in_beat_t                 in_data,
  output logic                          in_stall,
  output logic                          push_valid,
  output logic [MAX_CODE_BITS-1:0]      push_code,
  output code_tag_t                     push_tag,
  input  wire logic                     q_full
);

  localparam int BUF_W  = MAX_CODE_BITS + BYTE_BITS - 1;
  localparam int HELD_W = $clog2(BUF_W + 1);
  localparam logic [MAX_CODE_BITS-1:0] ONES = '1;

  logic [BUF_W-1:0]  buf_r, buf_nxt, base_buf;
  logic [HELD_W-1:0] held_r, held_nxt, base_held, held_left, bits_h;
  logic              busy_r, busy_nxt;
  logic              first_r, first_nxt;
  logic              clr_r, clr_nxt;
  logic [2:0]        bits;
  logic              accept;
  logic              last_code;

  assign bits      = eff_code_bits(cfg.code_bits, 3'(MAX_CODE_BITS));
  assign bits_h    = HELD_W'(bits);
  assign held_left = held_r - bits_h;
  assign last_code = (held_left < bits_h);

  // one byte at a time; codes are split off one per cycle while the queue is not full
  assign in_stall   = busy_r;
  assign accept     = in_valid && !busy_r;
  assign push_valid = busy_r && !q_full;
  assign push_code  = buf_r[MAX_CODE_BITS-1:0] & ~(ONES << bits);
  assign push_tag   = '{first: first_r, clr: clr_r, last: last_code};

  assign base_buf  = in_data.glyph_start ? '0 : buf_r;
  assign base_held = in_data.glyph_start ? '0 : held_r;

  always_comb begin
    buf_nxt   = buf_r;
    held_nxt  = held_r;
    busy_nxt  = busy_r;
    first_nxt = first_r;
    clr_nxt   = clr_r;
    if (accept) begin
      // merge the new byte above the bits still held
      buf_nxt   = base_buf | (BUF_W'(in_data.data_byte) << base_held);
      held_nxt  = base_held + HELD_W'(BYTE_BITS);
      busy_nxt  = 1'b1;
      first_nxt = 1'b1;
      clr_nxt   = in_data.glyph_start;
    end else if (push_valid) begin
      buf_nxt   = buf_r >> bits;
      held_nxt  = held_left;
      first_nxt = 1'b0;
      clr_nxt   = 1'b0;
      if (last_code) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= '0;
      held_r  <= '0;
      busy_r  <= 1'b0;
      first_r <= 1'b0;
      clr_r   <= 1'b0;
    end else begin
      buf_r   <= buf_nxt;
      held_r  <= held_nxt;
      busy_r  <= busy_nxt;
      first_r <= first_nxt;
      clr_r   <= clr_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/glrd_back.sv
`default_nettype none

module glrd_back import glrd_pkg::*; #(
  parameter int MAX_CODE_BITS = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     q_valid,
  input  wire logic [MAX_CODE_BITS-1:0] q_code,
  input  wire code_tag_t                q_tag,
  output logic                          q_pop,
  output logic                          out_valid,
  output out_beat_t                     out_data,
  input  wire logic                     out_stall
);

  localparam int CNT_W = MAX_CODE_BITS;
  localparam logic [CNT_W-1:0] ONES = '1;

  logic             active_r, active_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             level_r, level_nxt;
  logic             code_last_r, code_last_nxt;
  logic [7:0]       col_r, col_nxt, row_r, row_nxt;
  logic             run_level_r, run_level_nxt;
  logic             finished_r, finished_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_r, out_nxt;

  logic [2:0]       bits;
  logic             plain;
  logic [CNT_W-1:0] mask, count;
  logic             toggle, pop, emit, size_zero, row_end, done, last_pix;

  assign bits   = eff_code_bits(cfg.code_bits, 3'(MAX_CODE_BITS));
  assign plain  = (bits == 3'd1);
  assign mask   = ~(ONES << bits);
  // a full-length code continues the run and keeps the level
  assign count  = plain ? CNT_W'(1) : ((q_code == mask) ? mask : q_code + CNT_W'(1));
  assign toggle = !plain && (q_code != mask);

  assign size_zero = (cfg.glyph_width == 8'd0) || (cfg.glyph_height == 8'd0);
  assign row_end   = ({1'b0, col_r} + 9'd1) >= {1'b0, cfg.glyph_width};
  assign done      = row_end && (({1'b0, row_r} + 9'd1) >= {1'b0, cfg.glyph_height});
  assign last_pix  = done || ((rem_r == CNT_W'(1)) && code_last_r);

  assign pop  = !active_r && q_valid;
  assign emit = active_r && (!out_valid_r || !out_stall);

  assign q_pop     = pop;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    active_nxt    = active_r;
    rem_nxt       = rem_r;
    level_nxt     = level_r;
    code_last_nxt = code_last_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    run_level_nxt = run_level_r;
    finished_nxt  = finished_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    // take a code: glyph clear, size check, then load the run
    if (pop) begin
      if (q_tag.clr) begin
        col_nxt       = 8'd0;
        row_nxt       = 8'd0;
        run_level_nxt = cfg.start_level;
        finished_nxt  = 1'b0;
      end
      if (q_tag.first && size_zero) begin
        finished_nxt = 1'b1;
      end
      if (!finished_nxt) begin
        active_nxt    = 1'b1;
        rem_nxt       = count;
        level_nxt     = plain ? q_code[0] : run_level_nxt;
        code_last_nxt = q_tag.last;
        if (toggle) begin
          run_level_nxt = !run_level_nxt;
        end
      end
    end

    // one pixel per cycle into the output register while the output is not stalled
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt = '{pixel_on: level_r, column: col_r, row: row_r,
                  glyph_done: done, last_of_byte: last_pix};
      rem_nxt = rem_r - CNT_W'(1);
      if (done) begin
        finished_nxt = 1'b1;
        active_nxt   = 1'b0;
      end else begin
        if (row_end) begin
          col_nxt = 8'd0;
          row_nxt = row_r + 8'd1;
        end else begin
          col_nxt = col_r + 8'd1;
        end
        if (rem_r == CNT_W'(1)) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      col_r       <= 8'd0;
      row_r       <= 8'd0;
      run_level_r <= 1'b0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      run_level_r <= run_level_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // run payload and output beat
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    level_r     <= level_nxt;
    code_last_r <= code_last_nxt;
    out_r       <= out_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/glyph_run_length_decoder.sv
// A byte passes the front's bit buffer, the queue, the run and output registers.
// One pixel per cycle while out_stall is low; the pixel stage loads each run code
// before its pixels; the front takes a byte in, then splits it (8 codes at width 1).
// A byte waits in_stall until the front has split the previous byte into codes.
// Reset (rst_n low at a clock edge) empties the queue and output register, clears the
// bit buffer and position, and restores code_bits 1, start level 0, size 8 x 8.
`default_nettype none

module glyph_run_length_decoder import glrd_pkg::*; #(
  parameter int MAX_CODE_BITS = 5
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire in_beat_t   in_data,
  output logic            in_stall,
  output logic            out_valid,
  output out_beat_t       out_data,
  input  wire logic       out_stall,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int Q_W = MAX_CODE_BITS + $bits(code_tag_t);

  cfg_t                     cfg_r;
  logic                     push_valid, q_full, q_valid, q_pop;
  logic [MAX_CODE_BITS-1:0] push_code, q_code;
  code_tag_t                push_tag, q_tag;
  logic [Q_W-1:0]           q_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{code_bits: 3'd1, start_level: 1'b0,
                 glyph_width: 8'd8, glyph_height: 8'd8};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CODE_BITS:    cfg_r.code_bits    <= cfg_data[2:0];
        REG_START_LEVEL:  cfg_r.start_level  <= cfg_data[0];
        REG_GLYPH_WIDTH:  cfg_r.glyph_width  <= cfg_data;
        REG_GLYPH_HEIGHT: cfg_r.glyph_height <= cfg_data;
      endcase
    end
  end

  glrd_front #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .push_valid (push_valid),
    .push_code  (push_code),
    .push_tag   (push_tag),
    .q_full     (q_full)
  );

  glrd_queue #(.WIDTH(Q_W)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  ({push_tag, push_code}),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  assign q_code = q_data[MAX_CODE_BITS-1:0];
  assign q_tag  = code_tag_t'(q_data[Q_W-1:MAX_CODE_BITS]);

  glrd_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_code    (q_code),
    .q_tag     (q_tag),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/glrd_checker.sv
`default_nettype none

module glrd_props import glrd_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire out_beat_t out_data,
  input wire logic      out_stall
);

  // a stalled pixel beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // the final pixel of a glyph always closes its byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.glyph_done |-> out_data.last_of_byte)
    else $error("glyph_done without last_of_byte");

  // positions stay inside a 255 x 255 glyph
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.column != 8'hFF) && (out_data.row != 8'hFF))
    else $error("pixel position out of range");

  // reset leaves the block empty and ready for a byte
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind glyph_run_length_decoder glrd_props u_glrd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_data  (out_data),
  .out_stall (out_stall)
);

`default_nettype wire
